// ===== hw/rtl/flg_pkg.sv =====
package flg_pkg;

    // audio sample and result width
    localparam int SAMPLE_W = 16;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_GAIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_DELAY = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SWING      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LFO_STEP   = 2'd3;

    localparam int GAIN_W  = 13;
    localparam int DELAY_W = 8;
    localparam int SWING_W = 8;
    localparam int STEP_W  = 23;

    localparam logic [GAIN_W-1:0]  GAIN_RST  = 13'd4096;
    localparam logic [DELAY_W-1:0] DELAY_RST = 8'd100;
    localparam logic [SWING_W-1:0] SWING_RST = 8'd128;
    localparam logic [STEP_W-1:0]  STEP_RST  = 23'd2097;

    // sine polynomial coefficients, Q15
    localparam logic [15:0] SIN_C3 = 16'd2320;
    localparam logic [15:0] SIN_C2 = 16'd21023;
    localparam logic [15:0] SIN_C1 = 16'd51472;
    localparam logic [15:0] SIN_MAX = 16'd32767;

    // mix divide: numerator x*2^20 + g*tap, denominator (4096+g)*256
    localparam int NUM_W = 40;
    localparam int DEN_W = 22;
    localparam int Q_W   = 16;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hw/rtl/flg_ram.sv =====
module flg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/flg_div.sv =====
module flg_div
    import flg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output div_stat_t               stat,
    output logic signed [Q_W-1:0]   quot
);

    localparam int MAG_W = NUM_W - 1;
    localparam int CNT_W = $clog2(Q_W);

    logic [MAG_W-1:0] rem_reg;
    logic [MAG_W-1:0] dsh_reg;
    logic [Q_W-1:0]   q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [NUM_W-1:0] num_abs;
    logic             fits;

    assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign fits    = (rem_reg >= dsh_reg);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(Q_W - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num_abs[MAG_W-1:0];
            dsh_reg <= MAG_W'({den, {(Q_W-1){1'b0}}});
            neg_reg <= num[NUM_W-1];
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = neg_reg ? $signed(-q_reg) : $signed(q_reg);

endmodule

// ===== hw/rtl/flanger_fractional_delay.sv =====
// Audio flanger with a sine-swept fractional delay line.
// Input channel s_*: one signed 16-bit sample per beat. Result channel m_*:
// one signed 16-bit flanged sample per input beat, in the same order.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write depth_gain (0),
// base_delay (1), swing (2) and lfo_step (3); write only while idle.
// Each sample runs through a sequencer: the sine value is built from a
// polynomial on one shared multiplier, the delay is formed and clamped,
// two taps are read from the delay ring memory, the tap is interpolated
// and scaled, then a radix-2 divider forms the mix.
// s_tready and m_tvalid both rise together once the result is loaded into a free
// result register, so a new sample is taken only after the last one is done.
// After reset the ring memory is zeroed by a clearing pass over its
// BUFFER_DEPTH entries, while s_tready stays low; configuration writes still land.
// The result sits in an output register; a new sample is accepted while it
// waits, and the block holds the next finished result until m_tready frees
// the register.
module flanger_fractional_delay
    import flg_pkg::*;
#(
    parameter int BUFFER_DEPTH     = 256,
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample_out
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int SB = $clog2(SINE_TABLE_DEPTH);
    localparam int DW = AW + 8;
    localparam logic signed [29:0] DMAX = 30'((BUFFER_DEPTH - 2) * 256 + 255);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_SQ    = 4'd2;
    localparam logic [3:0] ST_C1    = 4'd3;
    localparam logic [3:0] ST_C2    = 4'd4;
    localparam logic [3:0] ST_C3    = 4'd5;
    localparam logic [3:0] ST_C4    = 4'd6;
    localparam logic [3:0] ST_C5    = 4'd7;
    localparam logic [3:0] ST_DLY   = 4'd8;
    localparam logic [3:0] ST_RD0   = 4'd9;
    localparam logic [3:0] ST_RD1   = 4'd10;
    localparam logic [3:0] ST_T0    = 4'd11;
    localparam logic [3:0] ST_T1    = 4'd12;
    localparam logic [3:0] ST_T2    = 4'd13;
    localparam logic [3:0] ST_DST   = 4'd14;
    localparam logic [3:0] ST_DIV   = 4'd15;

    // control state
    logic [3:0]            state_reg, state_next;
    logic [AW-1:0]         clr_cnt_reg;
    logic [AW-1:0]         wp_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic                  m_valid_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic [DELAY_W-1:0]    base_reg;
    logic [SWING_W-1:0]    swing_reg;
    logic [STEP_W-1:0]     step_reg;

    // datapath
    logic [SAMPLE_W-1:0]   x_reg;
    logic [1:0]            quad_reg;
    logic [15:0]           sx_reg;
    logic [15:0]           x2_reg;
    logic signed [15:0]    s_reg;
    logic [DW-1:0]         d_reg;
    logic signed [15:0]    y0_reg;
    logic signed [24:0]    tap_reg;
    logic signed [43:0]    prod_reg;
    logic [SAMPLE_W-1:0]   m_data_reg;

    logic                  in_acc;
    logic                  out_load;
    logic [SB-1:0]         sin_idx;
    logic [15:0]           angle;
    logic [15:0]           ang_x;
    logic [15:0]           u_val;
    logic [15:0]           m_raw;
    logic [15:0]           m_sat;
    logic signed [29:0]    d_sum;
    logic [DW-1:0]         d_clamp;
    logic signed [16:0]    y_diff;
    logic signed [17:0]    mul_a;
    logic signed [25:0]    mul_b;
    logic signed [43:0]    mul_p;
    logic [AW-1:0]         k_val;
    logic [AW-1:0]         rd_addr;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [SAMPLE_W-1:0]   ram_wdata;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic                  div_start;
    logic signed [NUM_W-1:0] div_num;
    logic [DEN_W-1:0]      div_den;
    div_stat_t             div_stat;
    logic signed [Q_W-1:0] div_quot;

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DIV) && div_stat.done && (!m_valid_reg || m_tready);

    // phase to sine table angle, folded into the first quadrant
    assign sin_idx = phase_reg[PHASE_BITS-1 -: SB];
    assign angle   = {sin_idx, {(16 - SB){1'b0}}};
    assign ang_x   = angle[14] ? (16'd32768 - {1'b0, angle[13:0], 1'b0})
                               : {1'b0, angle[13:0], 1'b0};

    always_comb begin
        u_val = 16'(SIN_C2 - prod_reg[30:15]);
        if (state_reg == ST_C3) begin
            u_val = 16'(SIN_C1 - prod_reg[30:15]);
        end
    end

    assign m_raw = prod_reg[30:15];
    assign m_sat = (m_raw > SIN_MAX) ? SIN_MAX : m_raw;

    // delay in Q8.8: base*256 + floor(base*swing*sine / 32768), clamped
    assign d_sum = $signed({14'b0, base_reg, 8'b0}) + $signed({prod_reg[43], prod_reg[43:15]});
    always_comb begin
        if (d_sum < 0) begin
            d_clamp = '0;
        end else if (d_sum > DMAX) begin
            d_clamp = DW'(DMAX);
        end else begin
            d_clamp = DW'(d_sum);
        end
    end

    assign k_val   = d_reg[DW-1:8];
    assign rd_addr = (state_reg == ST_RD1) ? AW'(wp_reg - k_val - 2'd2)
                                           : AW'(wp_reg - k_val - 1'b1);
    assign y_diff  = $signed({ram_rdata[15], ram_rdata}) - $signed({y0_reg[15], y0_reg});

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ: begin
                mul_a = $signed({2'b0, sx_reg});
                mul_b = $signed({10'b0, sx_reg});
            end
            ST_C1: begin
                mul_a = $signed({2'b0, prod_reg[30:15]});
                mul_b = $signed({10'b0, SIN_C3});
            end
            ST_C2: begin
                mul_a = $signed({2'b0, u_val});
                mul_b = $signed({10'b0, x2_reg});
            end
            ST_C3: begin
                mul_a = $signed({2'b0, u_val});
                mul_b = $signed({10'b0, sx_reg});
            end
            ST_C4: begin
                mul_a = $signed({10'b0, base_reg});
                mul_b = $signed({18'b0, swing_reg});
            end
            ST_C5: begin
                mul_a = $signed({{2{s_reg[15]}}, s_reg});
                mul_b = $signed({10'b0, prod_reg[15:0]});
            end
            ST_T0: begin
                mul_a = $signed({y_diff[16], y_diff});
                mul_b = $signed({18'b0, d_reg[7:0]});
            end
            ST_T2: begin
                mul_a = $signed({5'b0, gain_reg});
                mul_b = $signed({tap_reg[24], tap_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == AW'(BUFFER_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:  state_next = ST_C1;
            ST_C1:  state_next = ST_C2;
            ST_C2:  state_next = ST_C3;
            ST_C3:  state_next = ST_C4;
            ST_C4:  state_next = ST_C5;
            ST_C5:  state_next = ST_DLY;
            ST_DLY: state_next = ST_RD0;
            ST_RD0: state_next = ST_RD1;
            ST_RD1: state_next = ST_T0;
            ST_T0:  state_next = ST_T1;
            ST_T1:  state_next = ST_T2;
            ST_T2:  state_next = ST_DST;
            ST_DST: state_next = ST_DIV;
            ST_DIV: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            wp_reg      <= '0;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load) begin
                wp_reg    <= wp_reg + 1'b1;
                phase_reg <= phase_reg + PHASE_BITS'(step_reg);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= GAIN_RST;
            base_reg  <= DELAY_RST;
            swing_reg <= SWING_RST;
            step_reg  <= STEP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEPTH_GAIN: gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_BASE_DELAY: base_reg  <= cfg_wdata[DELAY_W-1:0];
                REG_SWING:      swing_reg <= cfg_wdata[SWING_W-1:0];
                REG_LFO_STEP:   step_reg  <= cfg_wdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (in_acc) begin
            x_reg    <= s_tdata;
            quad_reg <= angle[15:14];
            sx_reg   <= ang_x;
        end
        if (state_reg == ST_C1) begin
            x2_reg <= prod_reg[30:15];
        end
        if (state_reg == ST_C4) begin
            s_reg <= quad_reg[1] ? $signed(-m_sat) : $signed(m_sat);
        end
        if (state_reg == ST_DLY) begin
            d_reg <= d_clamp;
        end
        if (state_reg == ST_RD1) begin
            y0_reg <= $signed(ram_rdata);
        end
        if (state_reg == ST_T1) begin
            tap_reg <= $signed({y0_reg[15], y0_reg, 8'b0}) + $signed(prod_reg[24:0]);
        end
        if (out_load) begin
            m_data_reg <= SAMPLE_W'(div_quot);
        end
    end

    // ring writes: zero fill after reset, then the input once its result is out
    assign ram_we    = (state_reg == ST_CLEAR) || out_load;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : wp_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : x_reg;

    flg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    assign div_start = (state_reg == ST_DST);
    assign div_num   = $signed({{4{x_reg[15]}}, x_reg, 20'b0}) + $signed(prod_reg[NUM_W-1:0]);
    assign div_den   = {14'(gain_reg) + 14'd4096, 8'b0};

    flg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hw/rtl/flg_checker.sv =====
module flg_checker
    import flg_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata
);

    logic s_beat;

    assign s_beat = s_tvalid && s_tready;

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // one sample in flight at a time
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> !s_tready)
        else $error("input taken while a sample is in flight");

    // a result needs a full pass of the sequencer after its input beat
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_beat))
        else $error("result appeared right after an input beat");

endmodule

bind flanger_fractional_delay flg_checker u_flg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/flanger_fractional_delay_test.sv =====
module flanger_fractional_delay_test;
    import flg_pkg::*;

    localparam int RING_DEPTH     = 256;
    localparam int SINE_DEPTH     = 256;
    localparam int LFO_BITS       = 24;
    localparam longint DELAY_MAX  = (RING_DEPTH - 2) * 256 + 255;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 126;
    localparam int MAX_REPORTS    = 20;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;    // [15:0] sample_in
    logic                  m_tvalid;
    logic                  m_tready;
    logic [SAMPLE_W-1:0]   m_tdata;    // [15:0] sample_out
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    flanger_fractional_delay dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // flanger state mirrored on the bench side
    logic signed [15:0] ring [RING_DEPTH];
    logic [7:0]         wr_ptr;
    logic [23:0]        lfo_phase_r;
    logic [GAIN_W-1:0]  gain_r;
    logic [DELAY_W-1:0] base_r;
    logic [SWING_W-1:0] swing_r;
    logic [STEP_W-1:0]  lfo_step_r;

    logic [15:0]        flanged_q [$];
    logic signed [15:0] want;

    int errors;
    int n_sent;
    int n_checked;
    int n_writes;
    int quiet_cycles;
    int hold_req;
    int rx_holding;
    int calm;

    // Q15 sine from the polynomial, one table entry
    function automatic longint sine_at(input logic [7:0] idx);
        longint a, q, x, x2, u, m;
        a = (longint'(idx) * 65536) / SINE_DEPTH;
        q = (a >> 14) & 3;
        x = (a & 16'h3FFF) << 1;
        if (q[0])
            x = 32768 - x;
        x2 = (x * x) >> 15;
        u = 21023 - ((2320 * x2) >> 15);
        u = 51472 - ((u * x2) >> 15);
        m = (u * x) >> 15;
        if (m > 32767)
            m = 32767;
        return (q < 2) ? m : -m;
    endfunction

    // advances the mirrored state by one sample and returns the flanged output
    function automatic logic [15:0] flange_sample(input logic signed [15:0] x);
        longint s, d, tap, num, den, y;
        int k, f;
        logic [7:0] p0, p1;
        s = sine_at(lfo_phase_r[LFO_BITS-1 -: 8]);
        // arithmetic shift gives the floor of the signed product
        d = longint'(base_r) * 256 + ((longint'(base_r) * longint'(swing_r) * s) >>> 15);
        if (d < 0)
            d = 0;
        if (d > DELAY_MAX)
            d = DELAY_MAX;
        k = int'(d >> 8);
        f = int'(d & 255);
        p0 = wr_ptr - 8'd1 - 8'(k);
        p1 = wr_ptr - 8'd2 - 8'(k);
        tap = longint'(ring[p0]) * (256 - f) + longint'(ring[p1]) * f;
        num = longint'(x) * 4096 * 256 + longint'(gain_r) * tap;
        den = (4096 + longint'(gain_r)) * 256;
        y = num / den;
        ring[wr_ptr] = x;
        wr_ptr = wr_ptr + 8'd1;
        lfo_phase_r = lfo_phase_r + {1'b0, lfo_step_r};
        return y[15:0];
    endfunction

    task automatic send_sample(input logic [15:0] x);
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        flanged_q.push_back(flange_sample(x));
        n_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // stop sending until every pending output is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (flanged_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_DEPTH_GAIN: gain_r     = val[GAIN_W-1:0];
            REG_BASE_DELAY: base_r     = val[DELAY_W-1:0];
            REG_SWING:      swing_r    = val[SWING_W-1:0];
            REG_LFO_STEP:   lfo_step_r = val[STEP_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(posedge aclk);
    endtask

    // narrow registers sometimes get junk in the unused upper bits
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] val,
                                                        input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 1) == 0)
            return val;
        return (junk & ~((CFG_DATA_W'(1) << width) - 1)) | val;
    endfunction

    task automatic set_config(input logic [GAIN_W-1:0] g, input logic [DELAY_W-1:0] b,
                              input logic [SWING_W-1:0] sw, input logic [STEP_W-1:0] st);
        write_reg(REG_DEPTH_GAIN, with_junk(CFG_DATA_W'(g), GAIN_W));
        write_reg(REG_BASE_DELAY, with_junk(CFG_DATA_W'(b), DELAY_W));
        write_reg(REG_SWING, with_junk(CFG_DATA_W'(sw), SWING_W));
        write_reg(REG_LFO_STEP, CFG_DATA_W'(st));
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // full-scale and edge values at reset settings, taps still read the cleared ring
    task automatic test_extremes();
        logic [15:0] vals [8];
        vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                 16'h0001, 16'h5555, 16'hAAAA, 16'h8001};
        foreach (vals[i]) begin
            send_sample(vals[i]);
            if (i % 3 == 1)
                idle_sender($urandom_range(1, 9));
        end
        drain();
    endtask

    // no mix gain: output follows the input
    task automatic test_zero_gain();
        write_reg(REG_DEPTH_GAIN, '0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h1234);
        drain();
    endtask

    // no delay, strongest gain: tap is the sample before, alternating full scale
    task automatic test_zero_delay();
        set_config(GAIN_W'(8191), '0, '0, STEP_RST);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        drain();
    endtask

    // longest delay and swing push the delay past the ring, so it saturates when the sine is not negative
    task automatic test_delay_clamp();
        set_config(GAIN_W'(8191), DELAY_W'(255), SWING_W'(255), STEP_W'(8388607));
        repeat (6) send_sample(random_sample());
        drain();
        set_config(GAIN_RST, DELAY_RST, SWING_RST, STEP_RST);
    endtask

    // receiver stalls long while samples keep coming, so the input backs up
    task automatic test_output_stall();
        hold_req = 1;
        while (!rx_holding) @(posedge aclk);
        repeat (12) send_sample(random_sample());
        drain();
    endtask

    task automatic test_random_settings();
        logic [GAIN_W-1:0]  g;
        logic [DELAY_W-1:0] b;
        logic [SWING_W-1:0] sw;
        logic [STEP_W-1:0]  st;
        int gap_odds;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0: g = '0;
                1: g = GAIN_W'(8191);
                2: g = GAIN_RST;
                default: g = GAIN_W'($urandom_range(0, 8191));
            endcase
            case ($urandom_range(0, 4))
                0: b = '0;
                1: b = DELAY_W'(160);
                2: b = DELAY_W'(255);
                3: b = DELAY_W'($urandom_range(1, 160));
                default: b = DELAY_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: sw = '0;
                1: sw = SWING_W'(128);
                2: sw = SWING_W'(255);
                default: sw = SWING_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: st = '0;
                1: st = STEP_W'(8388607);
                2: st = STEP_W'($urandom_range(0, 20000));
                default: st = STEP_W'($urandom);
            endcase
            set_config(g, b, sw, st);
            if (p == RANDOM_PHASES - 1)
                calm = 1;
            gap_odds = $urandom_range(2, 12);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (!calm && $urandom_range(1, gap_odds) == 1)
                    idle_sender($urandom_range(1, 9));
                send_sample(random_sample());
            end
            drain();
        end
    endtask

    // receiver: random stall bursts, ready stretches, and one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != 0) begin
                m_tready <= 1'b0;
                rx_holding = 1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge aclk);
                hold_req = 0;
                rx_holding = 0;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (flanged_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t unexpected output beat %0d", $time, $signed(m_tdata));
            end else begin
                want = flanged_q.pop_front();
                n_checked++;
                if (m_tdata !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t sample_out mismatch: expected %0d, got %0d",
                                 $time, want, $signed(m_tdata));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t no beat for %0d cycles, %0d outputs still pending",
                     $time, quiet_cycles, flanged_q.size());
            $display("flanger_fractional_delay_test: errors");
            $finish;
        end
    end

    initial begin
        aclk = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_writes = 0;
        quiet_cycles = 0;
        hold_req = 0;
        rx_holding = 0;
        calm = 0;
        foreach (ring[i])
            ring[i] = '0;
        wr_ptr = '0;
        lfo_phase_r = '0;
        gain_r = GAIN_RST;
        base_r = DELAY_RST;
        swing_r = SWING_RST;
        lfo_step_r = STEP_RST;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_extremes();
        test_zero_gain();
        test_zero_delay();
        test_delay_clamp();
        test_output_stall();
        test_random_settings();

        drain();
        $display("run covered %0d samples and %0d register writes, %0d outputs checked",
                 n_sent, n_writes, n_checked);
        $display("settings included zero gain and delay, saturated delay, long output stall");
        if (errors == 0 && flanged_q.size() == 0) begin
            $display("flanger_fractional_delay_test: clean");
        end else begin
            $display("flanger_fractional_delay_test: errors");
        end
        $finish;
    end

endmodule
